// ===== sv/lbdh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbdh_pkg: shared types and constants of the duration histogram
// Command codes, the queued command format, the result bundle, the sequencer
// states and the build-time log2 used to derive the bin scale constants.
// ----------------------------------------------------------------------------
package lbdh_pkg;

	localparam logic [1:0] CMD_RECORD = 2'd0;
	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam int FRAC_BITS = 44;
	localparam logic [31:0] BIN_SAT = 32'hFFFF_FFFF;
	localparam logic [39:0] CNT_MAX = 40'hFF_FFFF_FFFF;
	localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

	typedef enum logic [1:0] {
		OP_RECORD,
		OP_READ,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t op;
		logic signed [47:0] sample;
		logic [9:0] index;
	} item_t;

	typedef struct packed {
		logic [9:0] bin_number;
		logic [31:0] bin_total;
		logic [39:0] samples_seen;
		logic signed [47:0] smallest;
		logic signed [47:0] largest;
		logic signed [63:0] running_sum;
		logic signed [47:0] running_mean;
		logic [63:0] sample_variance;
	} result_t;

	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_RD_ISSUE,
		ST_RD_DATA,
		ST_NORM,
		ST_SQ_GO,
		ST_SQ_WAIT,
		ST_SCALE_GO,
		ST_SCALE_WAIT,
		ST_RCP_GO,
		ST_RCP_WAIT,
		ST_FIX_GO,
		ST_FIX_WAIT,
		ST_BIN_READ,
		ST_BIN_LOAD,
		ST_MDIV_GO,
		ST_MDIV_WAIT,
		ST_DEV,
		ST_DMUL_GO,
		ST_DMUL_WAIT,
		ST_VAR_GO,
		ST_VDIV_WAIT,
		ST_OUT
	} state_t;

	// Log2 of an integer in Q.44, evaluated only at elaboration for constants.
	function automatic logic [63:0] log2_q44(input logic [63:0] x);
		logic [63:0] m;
		logic [63:0] r;
		logic [127:0] p;
		int k;
		int j;
		int i;
		k = 0;
		for (j = 0; j <= 62; j++) begin
			if (x[j]) begin
				k = j;
			end
		end
		m = x << (62 - k);
		r = 64'(k) << FRAC_BITS;
		for (i = 1; i <= FRAC_BITS; i++) begin
			p = {64'd0, m} * {64'd0, m};
			m = p[125:62];
			if (m[63]) begin
				m = m >> 1;
				r = r | (64'd1 << (FRAC_BITS - i));
			end
		end
		if (x == 64'd0) begin
			r = 64'd0;
		end
		return r;
	endfunction

endpackage

// ===== sv/log_binned_duration_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_binned_duration_histogram: log-binned duration histogram with statistics
// Records signed Q40.8 durations into log-spaced bins and keeps min, max,
// saturating sum and count, Welford mean and sample variance.
// ----------------------------------------------------------------------------
//
// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------------------
// command  | cmd_valid / cmd_ready | cmd, sample_time, read_index
// result   | res_valid / res_ready | bin_number, bin_total, samples_seen,
//          |                       | smallest, largest, running_sum,
//          |                       | running_mean, sample_variance
//
// Sequence: commands run one at a time in the sequencer. A record whose
// sample lies outside the edges takes one division for the mean, one multiply
// for the squared deviation unless the two deviations have opposite signs,
// and, from two samples on, one division for the variance. Inside the edges,
// add a normalization shift per leading zero of the sample, 44 log2 squarings
// on the shared four-pass multiplier, a scaling multiply and two more
// multiplies that divide by the constant bin scale through its reciprocal.
// Reset: after reset the bin store is zeroed by a pass over all BIN_COUNT
// bins, during which no command transaction is taken.
// Stalls: a two-entry queue takes commands while the sequencer is busy, and a
// result register holds a finished result while the next command runs.
//
module log_binned_duration_histogram #(
	parameter int     BIN_COUNT   = 1024,
	parameter int     DECADE_SPAN = 6,
	parameter longint LOW_EDGE    = 256,
	parameter longint HIGH_EDGE   = 256000000
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  logic [1:0]           cmd,
	input  logic signed [47:0]   sample_time,
	input  logic [9:0]           read_index,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic [9:0]           bin_number,
	output logic [31:0]          bin_total,
	output logic [39:0]          samples_seen,
	output logic signed [47:0]   smallest,
	output logic signed [47:0]   largest,
	output logic signed [63:0]   running_sum,
	output logic signed [47:0]   running_mean,
	output logic [63:0]          sample_variance
);

	// Queue head handed from the intake to the sequencer.
	lbdh_pkg::item_t head;
	logic head_valid;
	logic pop;
	// The intake holds off while the bin store is being zeroed after reset.
	logic init_busy;
	lbdh_pkg::result_t res;

	lbdh_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.sample_time (sample_time),
		.read_index  (read_index),
		.hold        (init_busy),
		.pop         (pop),
		.head        (head),
		.head_valid  (head_valid)
	);

	lbdh_back #(
		.BIN_COUNT   (BIN_COUNT),
		.DECADE_SPAN (DECADE_SPAN),
		.LOW_EDGE    (LOW_EDGE),
		.HIGH_EDGE   (HIGH_EDGE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.init_busy  (init_busy),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// Every result transaction carries the statistics as they stood after
	// its command.
	assign bin_number = res.bin_number;
	assign bin_total = res.bin_total;
	assign samples_seen = res.samples_seen;
	assign smallest = res.smallest;
	assign largest = res.largest;
	assign running_sum = res.running_sum;
	assign running_mean = res.running_mean;
	assign sample_variance = res.sample_variance;

endmodule

// ===== sv/lbdh_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbdh_front: command intake and two-entry queue
// Accepts command transactions, sorts them into record, read and clear, and
// holds them until the sequencer takes them.
// ----------------------------------------------------------------------------
module lbdh_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  logic [1:0]           cmd,
	input  logic signed [47:0]   sample_time,
	input  logic [9:0]           read_index,
	input  logic                 hold,
	input  logic                 pop,
	output lbdh_pkg::item_t      head,
	output logic                 head_valid
);

	lbdh_pkg::item_t ent_q [2];
	lbdh_pkg::item_t incoming;
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic push;

	always_comb begin
		incoming.sample = sample_time;
		incoming.index = read_index;
		unique case (cmd)
			lbdh_pkg::CMD_RECORD: incoming.op = lbdh_pkg::OP_RECORD;
			lbdh_pkg::CMD_CLEAR: incoming.op = lbdh_pkg::OP_CLEAR;
			default: incoming.op = lbdh_pkg::OP_READ;
		endcase
	end

	assign cmd_ready = (cnt_q != 2'd2) && !hold;
	assign push = cmd_valid && cmd_ready;
	assign head = ent_q[rd_q];
	assign head_valid = (cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= incoming;
		end
	end

endmodule

// ===== sv/lbdh_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbdh_mul: iterative 64x64 multiplier
// Forms the 128-bit product from four registered 32x32 partial products.
// ----------------------------------------------------------------------------
module lbdh_mul (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [63:0]   a,
	input  logic [63:0]   b,
	output logic          done,
	output logic [127:0]  prod
);

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [127:0] acc_q;
	logic [63:0] pp_s1;
	logic [1:0] sh_s1;
	logic pv_s1;
	logic [2:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [31:0] a_half;
	logic [31:0] b_half;
	logic [127:0] pp_shifted;

	assign a_half = cnt_q[0] ? a_q[63:32] : a_q[31:0];
	assign b_half = cnt_q[1] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		case (sh_s1)
			2'd0: pp_shifted = {64'd0, pp_s1};
			2'd1: pp_shifted = {32'd0, pp_s1, 32'd0};
			default: pp_shifted = {pp_s1, 64'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= 3'd0;
			pv_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			pv_s1 <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 3'd0;
			end else if (busy_q) begin
				if (!cnt_q[2]) begin
					pv_s1 <= 1'b1;
					cnt_q <= cnt_q + 3'd1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= 128'd0;
		end else begin
			if (busy_q && !cnt_q[2]) begin
				pp_s1 <= a_half * b_half;
				sh_s1 <= {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
			end
			if (pv_s1) begin
				acc_q <= acc_q + pp_shifted;
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ===== sv/lbdh_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbdh_div: radix-2 restoring divider
// Unsigned 64-bit by 64-bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lbdh_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [63:0]   num,
	input  logic [63:0]   den,
	output logic          done,
	output logic [63:0]   quo
);

	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] den_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [64:0] shifted;
	logic fits;

	assign shifted = {rem_q, quo_q[63]};
	assign fits = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= 6'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 64'd0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? 64'(shifted - {1'b0, den_q}) : shifted[63:0];
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

// ===== sv/lbdh_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbdh_back: command sequencer, bin store and running statistics
// Executes queued commands one at a time: bin choice by iterative log2,
// bin count update, Welford mean and squared deviations, and the variance.
// ----------------------------------------------------------------------------
module lbdh_back #(
	parameter int     BIN_COUNT   = 1024,
	parameter int     DECADE_SPAN = 6,
	parameter longint LOW_EDGE    = 256,
	parameter longint HIGH_EDGE   = 256000000
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lbdh_pkg::item_t      head,
	input  logic                 head_valid,
	output logic                 pop,
	output logic                 init_busy,
	output logic                 res_valid,
	input  logic                 res_ready,
	output lbdh_pkg::result_t    res
);

	localparam int AW = $clog2(BIN_COUNT);
	localparam logic [63:0] LG_LOW = lbdh_pkg::log2_q44(64'(LOW_EDGE));
	localparam logic [63:0] DEN = 64'(DECADE_SPAN) * lbdh_pkg::log2_q44(64'd10);
	localparam logic [63:0] EPS = DEN / 64'd1000000000;
	// Reciprocal of the bin scale with 109 fraction bits. The estimate taken
	// from the top 19 product bits is exact or one low, and one compare of
	// the remainder fixes it.
	localparam logic [127:0] RECIP_FULL = (128'd1 << 109) / {64'd0, DEN};
	localparam logic [63:0] RECIP = RECIP_FULL[63:0];
	localparam logic [AW-1:0] LAST_BIN = AW'(BIN_COUNT - 1);

	lbdh_pkg::state_t state_q;
	lbdh_pkg::state_t next_state;

	logic [31:0] bins_q [BIN_COUNT];
	logic [31:0] rd_q;
	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0] mem_wdata;
	logic [AW-1:0] mem_raddr;

	lbdh_pkg::item_t item_q;
	logic [63:0] m_q;
	logic [5:0] k_q;
	logic [63:0] r_q;
	logic [5:0] it_q;
	logic [63:0] num_q;
	logic [18:0] qe_q;
	logic [AW-1:0] bin_q;
	logic [9:0] bnum_q;
	logic [31:0] btot_q;
	logic signed [63:0] delta_q;
	logic [AW-1:0] sweep_q;

	logic [39:0] count_q;
	logic signed [47:0] min_q;
	logic signed [47:0] max_q;
	logic signed [63:0] sum_q;
	logic signed [63:0] mean_q;
	logic [63:0] sq_q;
	logic [63:0] var_q;
	lbdh_pkg::result_t res_q;
	logic res_valid_q;

	logic mul_start;
	logic [63:0] mul_a;
	logic [63:0] mul_b;
	logic mul_done;
	logic [127:0] mul_prod;
	logic div_start;
	logic [63:0] div_num;
	logic [63:0] div_den;
	logic div_done;
	logic [63:0] div_quo;

	logic signed [63:0] head_s64;
	logic head_low;
	logic head_high;
	logic signed [63:0] s64;
	logic signed [63:0] v;
	logic signed [63:0] delta2;
	logic [63:0] mag_delta;
	logic [63:0] mag_delta2;
	logic skip_dev;
	logic [63:0] d;
	logic [63:0] mn;
	logic [31:0] new_cnt;
	logic sweep_last;
	logic out_free;
	logic [63:0] term;
	logic [64:0] sq_sum;
	logic [63:0] mean_step;
	logic [63:0] rem_fix;
	logic [63:0] q_fix;

	lbdh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	lbdh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign head_s64 = {{16{head.sample[47]}}, head.sample};
	assign head_low = (head_s64 <= 64'(LOW_EDGE));
	assign head_high = (head_s64 >= 64'(HIGH_EDGE));
	assign s64 = {{16{item_q.sample[47]}}, item_q.sample};
	assign v = s64 <<< 8;
	assign delta2 = v - mean_q;
	assign mag_delta = delta_q[63] ? 64'(-delta_q) : 64'(delta_q);
	assign mag_delta2 = delta2[63] ? 64'(-delta2) : 64'(delta2);
	assign skip_dev = (delta_q[63] != delta2[63]) && (delta_q != 64'sd0) && (delta2 != 64'sd0);
	assign d = (r_q > LG_LOW) ? r_q - LG_LOW : 64'd0;
	assign mn = mul_prod[125:62];
	assign new_cnt = (rd_q == lbdh_pkg::BIN_SAT) ? rd_q : rd_q + 32'd1;
	assign sweep_last = (sweep_q == LAST_BIN);
	assign out_free = !res_valid_q || res_ready;
	assign term = (mul_prod[127:80] != 48'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : mul_prod[79:16];
	assign sq_sum = {1'b0, sq_q} + {1'b0, term};
	assign mean_step = delta_q[63] ? 64'(-div_quo) : div_quo;
	assign rem_fix = num_q - mul_prod[63:0];
	assign q_fix = {45'd0, qe_q} + ((rem_fix >= DEN) ? 64'd1 : 64'd0);

	// Next state.
	always_comb begin
		next_state = state_q;
		unique case (state_q)
			lbdh_pkg::ST_INIT: if (sweep_last) next_state = lbdh_pkg::ST_IDLE;
			lbdh_pkg::ST_IDLE: begin
				if (head_valid) begin
					unique case (head.op)
						lbdh_pkg::OP_CLEAR: next_state = lbdh_pkg::ST_CLEAR;
						lbdh_pkg::OP_RECORD: begin
							next_state = (head_low || head_high) ? lbdh_pkg::ST_BIN_READ
								: lbdh_pkg::ST_NORM;
						end
						default: next_state = lbdh_pkg::ST_RD_ISSUE;
					endcase
				end
			end
			lbdh_pkg::ST_CLEAR: if (sweep_last) next_state = lbdh_pkg::ST_OUT;
			lbdh_pkg::ST_RD_ISSUE: next_state = lbdh_pkg::ST_RD_DATA;
			lbdh_pkg::ST_RD_DATA: next_state = lbdh_pkg::ST_OUT;
			lbdh_pkg::ST_NORM: if (m_q[62]) next_state = lbdh_pkg::ST_SQ_GO;
			lbdh_pkg::ST_SQ_GO: next_state = lbdh_pkg::ST_SQ_WAIT;
			lbdh_pkg::ST_SQ_WAIT: begin
				if (mul_done) begin
					next_state = (it_q == 6'(lbdh_pkg::FRAC_BITS - 1)) ? lbdh_pkg::ST_SCALE_GO
						: lbdh_pkg::ST_SQ_GO;
				end
			end
			lbdh_pkg::ST_SCALE_GO: next_state = lbdh_pkg::ST_SCALE_WAIT;
			lbdh_pkg::ST_SCALE_WAIT: if (mul_done) next_state = lbdh_pkg::ST_RCP_GO;
			lbdh_pkg::ST_RCP_GO: next_state = lbdh_pkg::ST_RCP_WAIT;
			lbdh_pkg::ST_RCP_WAIT: if (mul_done) next_state = lbdh_pkg::ST_FIX_GO;
			lbdh_pkg::ST_FIX_GO: next_state = lbdh_pkg::ST_FIX_WAIT;
			lbdh_pkg::ST_FIX_WAIT: if (mul_done) next_state = lbdh_pkg::ST_BIN_READ;
			lbdh_pkg::ST_BIN_READ: next_state = lbdh_pkg::ST_BIN_LOAD;
			lbdh_pkg::ST_BIN_LOAD: next_state = lbdh_pkg::ST_MDIV_GO;
			lbdh_pkg::ST_MDIV_GO: next_state = lbdh_pkg::ST_MDIV_WAIT;
			lbdh_pkg::ST_MDIV_WAIT: if (div_done) next_state = lbdh_pkg::ST_DEV;
			lbdh_pkg::ST_DEV: begin
				next_state = skip_dev ? lbdh_pkg::ST_VAR_GO : lbdh_pkg::ST_DMUL_GO;
			end
			lbdh_pkg::ST_DMUL_GO: next_state = lbdh_pkg::ST_DMUL_WAIT;
			lbdh_pkg::ST_DMUL_WAIT: if (mul_done) next_state = lbdh_pkg::ST_VAR_GO;
			lbdh_pkg::ST_VAR_GO: begin
				next_state = (count_q < 40'd2) ? lbdh_pkg::ST_OUT : lbdh_pkg::ST_VDIV_WAIT;
			end
			lbdh_pkg::ST_VDIV_WAIT: if (div_done) next_state = lbdh_pkg::ST_OUT;
			lbdh_pkg::ST_OUT: if (out_free) next_state = lbdh_pkg::ST_IDLE;
			default: next_state = lbdh_pkg::ST_IDLE;
		endcase
	end

	// Control outputs and unit operands.
	always_comb begin
		pop = 1'b0;
		init_busy = 1'b0;
		mul_start = 1'b0;
		mul_a = m_q;
		mul_b = m_q;
		div_start = 1'b0;
		div_num = num_q;
		div_den = DEN;
		mem_we = 1'b0;
		mem_waddr = sweep_q;
		mem_wdata = 32'd0;
		mem_raddr = bin_q;
		unique case (state_q)
			lbdh_pkg::ST_INIT: begin
				init_busy = 1'b1;
				mem_we = 1'b1;
			end
			lbdh_pkg::ST_IDLE: pop = head_valid;
			lbdh_pkg::ST_CLEAR: mem_we = 1'b1;
			lbdh_pkg::ST_RD_ISSUE: mem_raddr = AW'(item_q.index);
			lbdh_pkg::ST_SQ_GO: mul_start = 1'b1;
			lbdh_pkg::ST_SCALE_GO: begin
				mul_start = 1'b1;
				mul_a = d;
				mul_b = 64'(BIN_COUNT);
			end
			lbdh_pkg::ST_RCP_GO: begin
				mul_start = 1'b1;
				mul_a = num_q;
				mul_b = RECIP;
			end
			lbdh_pkg::ST_FIX_GO: begin
				mul_start = 1'b1;
				mul_a = {45'd0, qe_q};
				mul_b = DEN;
			end
			lbdh_pkg::ST_BIN_LOAD: begin
				mem_we = 1'b1;
				mem_waddr = bin_q;
				mem_wdata = new_cnt;
			end
			lbdh_pkg::ST_MDIV_GO: begin
				div_start = 1'b1;
				div_num = mag_delta;
				div_den = {24'd0, count_q};
			end
			lbdh_pkg::ST_DMUL_GO: begin
				mul_start = 1'b1;
				mul_a = mag_delta;
				mul_b = mag_delta2;
			end
			lbdh_pkg::ST_VAR_GO: begin
				div_start = (count_q >= 40'd2);
				div_num = sq_q;
				div_den = {24'd0, count_q - 40'd1};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bins_q[mem_waddr] <= mem_wdata;
		end
		rd_q <= bins_q[mem_raddr];
	end

	// Control and statistics registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbdh_pkg::ST_INIT;
			sweep_q <= '0;
			res_valid_q <= 1'b0;
			count_q <= 40'd0;
			min_q <= 48'sd0;
			max_q <= 48'sd0;
			sum_q <= 64'sd0;
			mean_q <= 64'sd0;
			sq_q <= 64'd0;
			var_q <= 64'd0;
		end else begin
			state_q <= next_state;
			if (state_q == lbdh_pkg::ST_INIT || state_q == lbdh_pkg::ST_CLEAR) begin
				sweep_q <= sweep_last ? '0 : sweep_q + AW'(1);
			end
			if (state_q == lbdh_pkg::ST_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				lbdh_pkg::ST_IDLE: begin
					if (head_valid && head.op == lbdh_pkg::OP_CLEAR) begin
						count_q <= 40'd0;
						min_q <= 48'sd0;
						max_q <= 48'sd0;
						sum_q <= 64'sd0;
						mean_q <= 64'sd0;
						sq_q <= 64'd0;
						var_q <= 64'd0;
					end
				end
				lbdh_pkg::ST_BIN_LOAD: begin
					if (count_q == 40'd0 || item_q.sample < min_q) min_q <= item_q.sample;
					if (count_q == 40'd0 || item_q.sample > max_q) max_q <= item_q.sample;
					if (s64 > 64'sd0 && sum_q > lbdh_pkg::SUM_MAX - s64) begin
						sum_q <= lbdh_pkg::SUM_MAX;
					end else if (s64 < 64'sd0 && sum_q < lbdh_pkg::SUM_MIN - s64) begin
						sum_q <= lbdh_pkg::SUM_MIN;
					end else begin
						sum_q <= sum_q + s64;
					end
					if (count_q != lbdh_pkg::CNT_MAX) count_q <= count_q + 40'd1;
				end
				lbdh_pkg::ST_MDIV_WAIT: begin
					if (div_done) mean_q <= mean_q + $signed(mean_step);
				end
				lbdh_pkg::ST_DMUL_WAIT: begin
					if (mul_done) sq_q <= sq_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq_sum[63:0];
				end
				lbdh_pkg::ST_VAR_GO: begin
					if (count_q < 40'd2) var_q <= 64'd0;
				end
				lbdh_pkg::ST_VDIV_WAIT: begin
					if (div_done) var_q <= div_quo;
				end
				default: begin
				end
			endcase
		end
	end

	// Per-command working registers.
	always_ff @(posedge clk) begin
		case (state_q)
			lbdh_pkg::ST_IDLE: begin
				item_q <= head;
				m_q <= {16'd0, head.sample};
				k_q <= 6'd62;
				bin_q <= head_low ? '0 : LAST_BIN;
				bnum_q <= (head.op == lbdh_pkg::OP_READ) ? head.index : 10'd0;
				btot_q <= 32'd0;
			end
			lbdh_pkg::ST_RD_DATA: begin
				btot_q <= (int'(item_q.index) < BIN_COUNT) ? rd_q : 32'd0;
			end
			lbdh_pkg::ST_NORM: begin
				if (!m_q[62]) begin
					m_q <= m_q << 1;
					k_q <= k_q - 6'd1;
				end else begin
					r_q <= {58'd0, k_q};
					it_q <= 6'd0;
				end
			end
			lbdh_pkg::ST_SQ_WAIT: begin
				if (mul_done) begin
					m_q <= mn[63] ? (mn >> 1) : mn;
					r_q <= {r_q[62:0], mn[63]};
					it_q <= it_q + 6'd1;
				end
			end
			lbdh_pkg::ST_SCALE_WAIT: begin
				if (mul_done) num_q <= mul_prod[63:0] + EPS;
			end
			lbdh_pkg::ST_RCP_WAIT: begin
				if (mul_done) qe_q <= mul_prod[127:109];
			end
			lbdh_pkg::ST_FIX_WAIT: begin
				if (mul_done) begin
					bin_q <= (q_fix > 64'(BIN_COUNT - 1)) ? LAST_BIN : q_fix[AW-1:0];
				end
			end
			lbdh_pkg::ST_BIN_LOAD: begin
				btot_q <= new_cnt;
				bnum_q <= 10'(bin_q);
				delta_q <= v - mean_q;
			end
			lbdh_pkg::ST_OUT: begin
				if (out_free) begin
					res_q.bin_number <= bnum_q;
					res_q.bin_total <= btot_q;
					res_q.samples_seen <= count_q;
					res_q.smallest <= min_q;
					res_q.largest <= max_q;
					res_q.running_sum <= sum_q;
					res_q.running_mean <= mean_q[55:8];
					res_q.sample_variance <= var_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

// ===== sv/lbdh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbdh_checker: port-level checks of the duration histogram
// Watches the command and result channels for held payloads and the result channel for consistent statistics.
// ----------------------------------------------------------------------------
module lbdh_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cmd_valid,
	input logic                 cmd_ready,
	input logic [1:0]           cmd,
	input logic signed [47:0]   sample_time,
	input logic [9:0]           read_index,
	input logic                 res_valid,
	input logic                 res_ready,
	input logic [9:0]           bin_number,
	input logic [31:0]          bin_total,
	input logic [39:0]          samples_seen,
	input logic signed [47:0]   smallest,
	input logic signed [47:0]   largest,
	input logic signed [63:0]   running_sum,
	input logic signed [47:0]   running_mean,
	input logic [63:0]          sample_variance
);

	held_command: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd)
			&& $stable(sample_time) && $stable(read_index))
		else $error("command changed while waiting");

	held_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(bin_number) && $stable(bin_total)
			&& $stable(samples_seen) && $stable(sample_variance))
		else $error("result changed while stalled");

	variance_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && samples_seen < 40'd2 |-> sample_variance == 64'd0)
		else $error("variance nonzero with fewer than two samples");

	empty_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && samples_seen == 40'd0 |-> smallest == 48'sd0 && largest == 48'sd0
			&& running_sum == 64'sd0 && running_mean == 48'sd0)
		else $error("statistics nonzero with no samples");

	min_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> smallest <= largest)
		else $error("smallest above largest");

endmodule

bind log_binned_duration_histogram lbdh_checker u_lbdh_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for log_binned_duration_histogram
// Feeds record, read and clear commands through the valid/ready command
// channel with bursty timing and checks every result transaction against a
// bit-accurate local model of the bins and the running statistics.
// ----------------------------------------------------------------------------
module testbench;

	// Command code 3 is not a member of op_t; the block answers it like a read.
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int NBINS = 1024;
	localparam longint LOW_LIMIT = 256;
	localparam longint HIGH_LIMIT = 256000000;
	localparam int SPAN = 6;
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int RANDOM_ITEMS = 600;

	typedef struct {
		logic [1:0] code;
		logic signed [47:0] sample;
		logic [9:0] index;
		bit drain_first;
	} command_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	logic [1:0] cmd = '0;
	logic signed [47:0] sample_time = '0;
	logic [9:0] read_index = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	logic [9:0] bin_number;
	logic [31:0] bin_total;
	logic [39:0] samples_seen;
	logic signed [47:0] smallest;
	logic signed [47:0] largest;
	logic signed [63:0] running_sum;
	logic signed [47:0] running_mean;
	logic [63:0] sample_variance;

	log_binned_duration_histogram uut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.cmd(cmd), .sample_time(sample_time), .read_index(read_index),
		.res_valid(res_valid), .res_ready(res_ready),
		.bin_number(bin_number), .bin_total(bin_total),
		.samples_seen(samples_seen), .smallest(smallest), .largest(largest),
		.running_sum(running_sum), .running_mean(running_mean),
		.sample_variance(sample_variance)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Local copy of the histogram state.
	logic [31:0] hist_bins [NBINS];
	logic [39:0] hist_count;
	logic signed [63:0] hist_min;
	logic signed [63:0] hist_max;
	logic signed [63:0] hist_sum;
	logic signed [63:0] hist_mean_q16;
	logic [63:0] hist_sq_dev;

	command_t pending_cmds[$];
	lbdh_pkg::result_t expected_results[$];
	int mismatches = 0;
	int records_done = 0;
	int reads_done = 0;
	int clears_done = 0;
	int results_checked = 0;
	int idle_cycles = 0;

	// Base-2 logarithm of an integer in Q.44 by repeated squaring of the
	// normalized mantissa, each square truncated.
	function automatic logic [63:0] log2_fixed(input logic [63:0] x);
		int k;
		int i;
		logic [63:0] mant;
		logic [63:0] lg;
		logic [127:0] sq;
		if (x == 64'd0) begin
			return 64'd0;
		end
		k = 62;
		while (k > 0 && !x[k]) begin
			k--;
		end
		mant = x << (62 - k);
		lg = 64'(k) << 44;
		for (i = 1; i <= 44; i++) begin
			sq = {64'd0, mant} * {64'd0, mant};
			mant = sq[125:62];
			if (mant[63]) begin
				mant = mant >> 1;
				lg = lg | (64'd1 << (44 - i));
			end
		end
		return lg;
	endfunction

	function automatic logic [9:0] bin_for_sample(input logic signed [63:0] s);
		logic [63:0] lg_s;
		logic [63:0] lg_low;
		logic [63:0] log_gap;
		logic [63:0] den;
		logic [63:0] num;
		logic [63:0] bin;
		if (s <= LOW_LIMIT) begin
			return 10'd0;
		end
		if (s >= HIGH_LIMIT) begin
			return 10'(NBINS - 1);
		end
		lg_s = log2_fixed(s);
		lg_low = log2_fixed(64'(LOW_LIMIT));
		log_gap = (lg_s > lg_low) ? lg_s - lg_low : 64'd0;
		den = 64'(SPAN) * log2_fixed(64'd10);
		num = log_gap * 64'(NBINS) + den / 64'd1000000000;
		bin = num / den;
		if (bin > 64'(NBINS - 1)) begin
			bin = 64'(NBINS - 1);
		end
		return bin[9:0];
	endfunction

	task automatic clear_histogram();
		for (int i = 0; i < NBINS; i++) begin
			hist_bins[i] = 32'd0;
		end
		hist_count = '0;
		hist_min = '0;
		hist_max = '0;
		hist_sum = '0;
		hist_mean_q16 = '0;
		hist_sq_dev = '0;
	endtask

	// Adds one sample: bin count, extremes, sum, count and the Welford update.
	task automatic add_sample(input logic signed [63:0] s, input logic [9:0] bin);
		logic signed [63:0] v;
		logic signed [63:0] delta;
		logic signed [63:0] delta2;
		logic [63:0] mag1;
		logic [63:0] mag2;
		logic [127:0] prod;
		logic [63:0] term;
		if (hist_bins[bin] != lbdh_pkg::BIN_SAT) begin
			hist_bins[bin]++;
		end
		if (hist_count == 0 || s < hist_min) begin
			hist_min = s;
		end
		if (hist_count == 0 || s > hist_max) begin
			hist_max = s;
		end
		if (s > 0 && hist_sum > lbdh_pkg::SUM_MAX - s) begin
			hist_sum = lbdh_pkg::SUM_MAX;
		end else if (s < 0 && hist_sum < lbdh_pkg::SUM_MIN - s) begin
			hist_sum = lbdh_pkg::SUM_MIN;
		end else begin
			hist_sum = hist_sum + s;
		end
		if (hist_count != lbdh_pkg::CNT_MAX) begin
			hist_count++;
		end
		v = s * 64'sd256;
		delta = v - hist_mean_q16;
		hist_mean_q16 = hist_mean_q16 + delta / $signed({24'd0, hist_count});
		delta2 = v - hist_mean_q16;
		// Opposite-signed deviations would make a negative square term: skip it.
		if ((delta < 0) != (delta2 < 0) && delta != 0 && delta2 != 0) begin
			return;
		end
		mag1 = delta < 0 ? -delta : delta;
		mag2 = delta2 < 0 ? -delta2 : delta2;
		prod = {64'd0, mag1} * {64'd0, mag2};
		term = (prod[127:80] != 0) ? '1 : prod[79:16];
		hist_sq_dev = (hist_sq_dev > ~term) ? '1 : hist_sq_dev + term;
	endtask

	// Applies one accepted command to the local state and queues its result.
	task automatic apply_command(input logic [1:0] code, input logic signed [47:0] sample,
			input logic [9:0] index);
		lbdh_pkg::result_t r;
		logic [9:0] bin;
		logic signed [63:0] mean_q8;
		r = '0;
		if (code == lbdh_pkg::CMD_RECORD) begin
			bin = bin_for_sample(64'(sample));
			add_sample(64'(sample), bin);
			r.bin_number = bin;
			r.bin_total = hist_bins[bin];
			records_done++;
		end else if (code == lbdh_pkg::CMD_CLEAR) begin
			clear_histogram();
			clears_done++;
		end else begin
			r.bin_number = index;
			r.bin_total = hist_bins[index];
			reads_done++;
		end
		mean_q8 = hist_mean_q16 >>> 8;
		r.samples_seen = hist_count;
		r.smallest = hist_min[47:0];
		r.largest = hist_max[47:0];
		r.running_sum = hist_sum;
		r.running_mean = mean_q8[47:0];
		r.sample_variance = (hist_count >= 2) ? hist_sq_dev / {24'd0, hist_count - 40'd1} : '0;
		expected_results.push_back(r);
	endtask

	// Sender: bursts of random length separated by random gaps. An item marked
	// drain_first is held back until every outstanding result has arrived.
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin
		logic hold_valid;
		command_t nxt;
		if (arst_n) begin
			hold_valid = cmd_valid;
			if (cmd_valid && cmd_ready) begin
				apply_command(cmd, sample_time, read_index);
				hold_valid = 1'b0;
			end
			if (!hold_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_cmds.size() > 0 &&
						!(pending_cmds[0].drain_first && expected_results.size() > 0)) begin
					nxt = pending_cmds.pop_front();
					cmd <= nxt.code;
					sample_time <= nxt.sample;
					read_index <= nxt.index;
					hold_valid = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
			cmd_valid <= hold_valid;
		end
	end

	// Receiver: the stall pattern is redrawn periodically among always ready,
	// random coin flips and a sparse periodic pulse.
	int stall_phase = 0;
	int stall_tick = 0;

	always @(posedge clk) begin
		logic ready_next;
		if (arst_n) begin
			stall_tick++;
			if (stall_tick % 300 == 0) begin
				stall_phase = $urandom_range(0, 2);
			end
			case (stall_phase)
				0: begin
					ready_next = 1'b1;
				end
				1: begin
					ready_next = 1'($urandom_range(0, 1));
				end
				default: begin
					ready_next = (stall_tick % 5 == 0);
				end
			endcase
			res_ready <= ready_next;
		end
	end

	// Monitor: compares each result transaction with the oldest expectation.
	always @(posedge clk) begin
		lbdh_pkg::result_t want;
		bit bad;
		if (arst_n && res_valid && res_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: unexpected result transaction, bin %0d", bin_number);
				end
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				bad = (want.bin_number != bin_number) || (want.bin_total != bin_total) ||
					(want.samples_seen != samples_seen) || (want.smallest != smallest) ||
					(want.largest != largest) || (want.running_sum != running_sum) ||
					(want.running_mean != running_mean) ||
					(want.sample_variance != sample_variance);
				if (bad) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("ERROR: result %0d mismatch", results_checked);
						$display("  expected bin %0d total %0d n %0d min %0d max %0d",
							want.bin_number, want.bin_total, want.samples_seen,
							want.smallest, want.largest);
						$display("           sum %0d mean %0d var %0d",
							want.running_sum, want.running_mean, want.sample_variance);
						$display("  actual   bin %0d total %0d n %0d min %0d max %0d",
							bin_number, bin_total, samples_seen, smallest, largest);
						$display("           sum %0d mean %0d var %0d",
							running_sum, running_mean, sample_variance);
					end
				end
			end
		end
	end

	// Watchdog: counts cycles without any transaction on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	function automatic command_t make_cmd(input logic [1:0] code,
			input logic signed [47:0] sample, input logic [9:0] index);
		command_t c;
		c.code = code;
		c.sample = sample;
		c.index = index;
		c.drain_first = 1'b0;
		return c;
	endfunction

	// Mostly positive durations spread over many octaves, sometimes near the
	// edges, rarely negative or completely random.
	function automatic logic signed [47:0] random_duration();
		int pick;
		int octave;
		logic [63:0] bits;
		pick = $urandom_range(0, 19);
		bits = {$urandom, $urandom};
		if (pick == 0) begin
			return bits[47:0];
		end else if (pick == 1) begin
			return -48'($urandom_range(0, 100000));
		end else if (pick == 2) begin
			return 48'(LOW_LIMIT) + 48'($urandom_range(0, 4)) - 48'sd2;
		end else if (pick == 3) begin
			return 48'(HIGH_LIMIT) + 48'($urandom_range(0, 4)) - 48'sd2;
		end
		octave = $urandom_range(0, 30);
		return 48'((bits & ((64'd1 << (octave + 1)) - 1)) | (64'd1 << octave));
	endfunction

	initial begin
		command_t c;
		int pick;
		clear_histogram();

		// Directed: edges of the bin range, extremes of the sample, the unused
		// command, reads at both ends, a clear and squared-deviation saturation.
		pending_cmds.push_back(make_cmd(lbdh_pkg::CMD_READ, '0, 10'd0));
		pending_cmds.push_back(make_cmd(lbdh_pkg::CMD_RECORD, 48'sd256, '0));
		pending_cmds.push_back(make_cmd(lbdh_pkg::CMD_RECORD, 48'sd257, '0));
		pending_cmds.push_back(make_cmd(lbdh_pkg::CMD_RECORD, 48'sd255999999, '0));
		pending_cmds.push_back(make_cmd(lbdh_pkg::CMD_RECORD, 48'sd256000000, '0));
		pending_cmds.push_back(make_cmd(lbdh_pkg::CMD_RECORD, 48'sd0, '0));
		pending_cmds.push_back(make_cmd(lbdh_pkg::CMD_RECORD, -48'sd1, '0));
		pending_cmds.push_back(make_cmd(lbdh_pkg::CMD_RECORD, 48'sh7FFF_FFFF_FFFF, '0));
		pending_cmds.push_back(make_cmd(lbdh_pkg::CMD_RECORD, 48'sh8000_0000_0000, '0));
		pending_cmds.push_back(make_cmd(lbdh_pkg::CMD_RECORD, 48'sh7FFF_FFFF_FFFF, '0));
		pending_cmds.push_back(make_cmd(lbdh_pkg::CMD_RECORD, 48'sh8000_0000_0000, '0));
		pending_cmds.push_back(make_cmd(lbdh_pkg::CMD_READ, '0, 10'd1023));
		pending_cmds.push_back(make_cmd(lbdh_pkg::CMD_READ, '0, 10'd0));
		pending_cmds.push_back(make_cmd(CMD_SPARE, 48'sh5555_5555_5555, 10'h2AA));
		pending_cmds.push_back(make_cmd(CMD_SPARE, 48'shAAAA_AAAA_AAAA, 10'h155));
		pending_cmds.push_back(make_cmd(lbdh_pkg::CMD_CLEAR, '0, '0));
		pending_cmds.push_back(make_cmd(lbdh_pkg::CMD_READ, '0, 10'd1023));
		pending_cmds.push_back(make_cmd(lbdh_pkg::CMD_RECORD, 48'sd1000, '0));
		c = make_cmd(lbdh_pkg::CMD_RECORD, 48'sd1000, '0);
		c.drain_first = 1'b1;
		pending_cmds.push_back(c);
		pending_cmds.push_back(make_cmd(lbdh_pkg::CMD_RECORD, 48'sd123456, '0));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				c = make_cmd(lbdh_pkg::CMD_RECORD, random_duration(), 10'($urandom));
			end else if (pick < 95) begin
				c = make_cmd(lbdh_pkg::CMD_READ, 48'({$urandom, $urandom}), 10'($urandom));
			end else if (pick < 97) begin
				c = make_cmd(CMD_SPARE, 48'({$urandom, $urandom}), 10'($urandom));
			end else begin
				c = make_cmd(lbdh_pkg::CMD_CLEAR, 48'({$urandom, $urandom}), 10'($urandom));
			end
			c.drain_first = (n == RANDOM_ITEMS / 2);
			pending_cmds.push_back(c);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_cmds.size() == 0 && !cmd_valid && expected_results.size() == 0);
		repeat (50) @(posedge clk);

		$display("Covered %0d records, %0d bin reads and %0d clears; %0d results checked.",
			records_done, reads_done, clears_done, results_checked);
		$display("Mismatching results: %0d, unclaimed expectations: %0d.",
			mismatches, expected_results.size());
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
